### sv/rdsw_pkg.sv
// rdsw_pkg: shared types, codes and constants of the remote door state watchdog
// depends on nothing; every other file takes names from here by scope

package rdsw_pkg;

  localparam int TIME_W = 48;
  localparam int CFG_W  = 24;
  localparam int ADDR_W = 3;

  // request kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_OPEN   = 2'd1;
  localparam logic [1:0] KIND_CLOSED = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  // door status codes
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_CLOSED  = 2'd1;
  localparam logic [1:0] ST_OPEN    = 2'd2;

  // register indexes
  localparam logic [ADDR_W-1:0] REG_TIMEOUT_OPEN   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT_CLOSED = 3'd1;
  localparam logic [ADDR_W-1:0] REG_HB_OPEN        = 3'd2;
  localparam logic [ADDR_W-1:0] REG_HB_CLOSED      = 3'd3;
  localparam logic [ADDR_W-1:0] REG_PUSH           = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_TIMEOUT_OPEN   = 24'd45000;
  localparam logic [CFG_W-1:0] RST_TIMEOUT_CLOSED = 24'd360000;
  localparam logic [CFG_W-1:0] RST_HB_OPEN        = 24'd30000;
  localparam logic [CFG_W-1:0] RST_HB_CLOSED      = 24'd300000;
  localparam logic [CFG_W-1:0] RST_PUSH           = 24'd300000;

  // duration split: 60000 = 32 * 1875
  localparam logic [10:0] DIV_LO      = 11'd1875;
  localparam logic [10:0] MOD_2P16    = 11'd1786;  // 2^16 mod 1875
  localparam logic [10:0] MOD_2P32    = 11'd421;   // 2^32 mod 1875
  localparam logic [27:0] RCP_MIN     = 28'd146601551; // ceil(2^38 / 1875)
  localparam int          RCP_MIN_SH  = 38;
  localparam logic [17:0] RCP_LO      = 18'd143166;    // ceil(2^28 / 1875)
  localparam int          RCP_LO_SH   = 28;
  localparam logic [13:0] RCP_SEC     = 14'd8389;      // ceil(2^20 / 125)
  localparam int          RCP_SEC_SH  = 20;
  // 65536 minutes in ms, from here on minutes saturate
  localparam logic [TIME_W-1:0] MIN_SAT_DUR = 48'd3932160000;
  localparam logic [15:0]       MIN_SAT     = 16'hFFFF;

  typedef struct packed {
    logic [CFG_W-1:0] timeout_open_ms;
    logic [CFG_W-1:0] timeout_closed_ms;
    logic [CFG_W-1:0] heartbeat_open_ms;
    logic [CFG_W-1:0] heartbeat_closed_ms;
    logic [CFG_W-1:0] push_interval_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic       notify_opened;
    logic       notify_closed;
    logic       went_stale;
    logic       heartbeat;
    logic       reminder;
    logic [1:0] door_status;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [TIME_W-1:0]   dur;
  } item_t;

endpackage

### sv/rdsw_if.sv
// rdsw_in_if / rdsw_out_if: valid-ready channels of the door watchdog
// depends on rdsw_pkg for field widths

interface rdsw_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [rdsw_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output kind, output now_ms, input ready);
  modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

interface rdsw_out_if;
  logic        valid;
  logic        ready;
  logic        notify_opened;
  logic        notify_closed;
  logic        went_stale;
  logic        heartbeat;
  logic        reminder;
  logic [1:0]  door_status;
  logic [15:0] open_minutes;
  logic [5:0]  open_seconds;

  modport source (output valid, output notify_opened, output notify_closed,
                  output went_stale, output heartbeat, output reminder,
                  output door_status, output open_minutes, output open_seconds,
                  input ready);
  modport sink   (input valid, input notify_opened, input notify_closed,
                  input went_stale, input heartbeat, input reminder,
                  input door_status, input open_minutes, input open_seconds,
                  output ready);
endinterface

### sv/rdsw_state.sv
// rdsw_state: input register and door state tracker, one request per cycle while item_ready is high
// depends on rdsw_pkg and rdsw_in_if

module rdsw_state (
  input  logic                clk,
  input  logic                rst_n,
  input  rdsw_pkg::cfg_regs_t cfg,
  rdsw_in_if.sink             in_chan,
  output logic                item_valid,
  input  logic                item_ready,
  output rdsw_pkg::item_t     item
);

  logic                        in_vld_r;
  logic [1:0]                  kind_r;
  logic [rdsw_pkg::TIME_W-1:0] now_r;

  logic                        known_r, known_nxt;
  logic                        open_r, open_nxt;
  logic [rdsw_pkg::TIME_W-1:0] last_rep_r, last_rep_nxt;
  logic [rdsw_pkg::TIME_W-1:0] opened_at_r, opened_at_nxt;
  logic [rdsw_pkg::TIME_W-1:0] last_rem_r, last_rem_nxt;
  logic [rdsw_pkg::TIME_W-1:0] last_hb_r, last_hb_nxt;

  logic [rdsw_pkg::TIME_W-1:0] el_rep, el_hb, el_rem;
  logic [rdsw_pkg::CFG_W-1:0]  tmo, hbi;
  logic                        stale, hb_due, rem_due;
  logic                        fire;
  rdsw_pkg::flags_t            flags;

  assign in_chan.ready = !in_vld_r || item_ready;
  assign fire          = in_vld_r && item_ready;

  assign el_rep = now_r - last_rep_r;
  assign el_hb  = now_r - last_hb_r;
  assign el_rem = now_r - last_rem_r;

  // tick checks, stale first since it picks the heartbeat interval
  assign tmo     = open_r ? cfg.timeout_open_ms : cfg.timeout_closed_ms;
  assign stale   = known_r && (el_rep >= rdsw_pkg::TIME_W'(tmo));
  assign hbi     = (open_r && !stale) ? cfg.heartbeat_open_ms : cfg.heartbeat_closed_ms;
  assign hb_due  = el_hb >= rdsw_pkg::TIME_W'(hbi);
  assign rem_due = known_r && open_r && !stale &&
                   (el_rem >= rdsw_pkg::TIME_W'(cfg.push_interval_ms));

  always_comb begin
    known_nxt     = known_r;
    open_nxt      = open_r;
    last_rep_nxt  = last_rep_r;
    opened_at_nxt = opened_at_r;
    last_rem_nxt  = last_rem_r;
    last_hb_nxt   = last_hb_r;
    flags         = '0;
    unique case (kind_r)
      rdsw_pkg::KIND_OPEN: begin
        if (!open_r) begin
          opened_at_nxt       = now_r;
          last_rem_nxt        = now_r;
          flags.notify_opened = 1'b1;
        end
        open_nxt     = 1'b1;
        known_nxt    = 1'b1;
        last_rep_nxt = now_r;
      end
      rdsw_pkg::KIND_CLOSED: begin
        flags.notify_closed = open_r;
        open_nxt            = 1'b0;
        known_nxt           = 1'b1;
        last_rep_nxt        = now_r;
        opened_at_nxt       = '0;
      end
      rdsw_pkg::KIND_TICK: begin
        if (stale) begin
          known_nxt     = 1'b0;
          open_nxt      = 1'b0;
          opened_at_nxt = '0;
        end
        if (hb_due) begin
          last_hb_nxt = now_r;
        end
        if (rem_due) begin
          last_rem_nxt = now_r;
        end
        flags.went_stale = stale;
        flags.heartbeat  = hb_due;
        flags.reminder   = rem_due;
      end
      rdsw_pkg::KIND_IGNORE: begin
      end
      default: begin
      end
    endcase
    flags.door_status = !known_nxt ? rdsw_pkg::ST_UNKNOWN :
                        (open_nxt ? rdsw_pkg::ST_OPEN : rdsw_pkg::ST_CLOSED);
  end

  assign item_valid  = in_vld_r;
  assign item.flags  = flags;
  assign item.dur    = now_r - opened_at_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      known_r     <= 1'b0;
      open_r      <= 1'b0;
      last_rep_r  <= '0;
      opened_at_r <= '0;
      last_rem_r  <= '0;
      last_hb_r   <= '0;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (fire) begin
        known_r     <= known_nxt;
        open_r      <= open_nxt;
        last_rep_r  <= last_rep_nxt;
        opened_at_r <= opened_at_nxt;
        last_rem_r  <= last_rem_nxt;
        last_hb_r   <= last_hb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      kind_r <= in_chan.kind;
      now_r  <= in_chan.now_ms;
    end
  end

endmodule

### sv/rdsw_split.sv
// rdsw_split: pipeline that turns the open duration into minutes and seconds
// depends on rdsw_pkg and rdsw_out_if; its last stage is the result register

module rdsw_split (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  output logic            item_ready,
  input  rdsw_pkg::item_t item,
  rdsw_out_if.source      out_chan
);

  localparam int NSTG = 7;

  logic [NSTG:1] vld_r;
  logic [NSTG:1] vin;
  logic [NSTG:1] rdy;
  logic [NSTG:1] ld;

  rdsw_pkg::flags_t f1_r, f2_r, f3_r, f4_r, f5_r, f6_r, f7_r;

  // stage 1: fold the duration modulo 1875, cut the minutes operand
  logic [26:0] y1_r, x1_r;
  logic        sat1_r;
  logic [1:0]  lo1_r, lo2_r, lo3_r, lo4_r, lo5_r;
  // stage 2..4: further folds and the minute product
  logic [16:0] pm2_r;
  logic        sat2_r;
  logic [21:0] z2_r;
  logic [15:0] mins3_r, mins4_r, mins5_r, mins6_r, mins7_r;
  logic [17:0] w3_r;
  logic [16:0] v4_r, v5_r;
  logic [5:0]  qq5_r;
  logic [12:0] t6_r;
  logic [5:0]  secs7_r;

  logic [54:0] prod_min;
  logic [34:0] prod_lo;
  logic [26:0] prod_sec;
  logic [16:0] rem_lo;

  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || out_chan.ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vin        = {vld_r[NSTG-1:1], item_valid};
  assign ld         = rdy & vin;
  assign item_ready = rdy[1];

  assign prod_min = 55'(x1_r) * 55'(rdsw_pkg::RCP_MIN);
  assign prod_lo  = 35'(v4_r) * 35'(rdsw_pkg::RCP_LO);
  assign rem_lo   = v5_r - 17'(qq5_r) * 17'(rdsw_pkg::DIV_LO);
  assign prod_sec = 27'(t6_r) * 27'(rdsw_pkg::RCP_SEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vin[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      f1_r   <= item.flags;
      y1_r   <= 27'(item.dur[20:5]) +
                27'(item.dur[36:21]) * 27'(rdsw_pkg::MOD_2P16) +
                27'(item.dur[47:37]) * 27'(rdsw_pkg::MOD_2P32);
      x1_r   <= item.dur[31:5];
      sat1_r <= item.dur >= rdsw_pkg::MIN_SAT_DUR;
      lo1_r  <= item.dur[4:3];
    end
    if (ld[2]) begin
      f2_r   <= f1_r;
      pm2_r  <= prod_min[rdsw_pkg::RCP_MIN_SH +: 17];
      sat2_r <= sat1_r;
      z2_r   <= 22'(y1_r[15:0]) + 22'(y1_r[26:16]) * 22'(rdsw_pkg::MOD_2P16);
      lo2_r  <= lo1_r;
    end
    if (ld[3]) begin
      f3_r    <= f2_r;
      mins3_r <= sat2_r ? rdsw_pkg::MIN_SAT : pm2_r[15:0];
      w3_r    <= 18'(z2_r[15:0]) + 18'(z2_r[21:16]) * 18'(rdsw_pkg::MOD_2P16);
      lo3_r   <= lo2_r;
    end
    if (ld[4]) begin
      f4_r    <= f3_r;
      mins4_r <= mins3_r;
      v4_r    <= 17'(w3_r[15:0]) + 17'(w3_r[17:16]) * 17'(rdsw_pkg::MOD_2P16);
      lo4_r   <= lo3_r;
    end
    if (ld[5]) begin
      f5_r    <= f4_r;
      mins5_r <= mins4_r;
      qq5_r   <= prod_lo[rdsw_pkg::RCP_LO_SH +: 6];
      v5_r    <= v4_r;
      lo5_r   <= lo4_r;
    end
    if (ld[6]) begin
      f6_r    <= f5_r;
      mins6_r <= mins5_r;
      t6_r    <= {rem_lo[10:0], lo5_r};
    end
    if (ld[7]) begin
      f7_r    <= f6_r;
      mins7_r <= f6_r.reminder ? mins6_r : '0;
      secs7_r <= f6_r.reminder ? prod_sec[rdsw_pkg::RCP_SEC_SH +: 6] : '0;
    end
  end

  assign out_chan.valid         = vld_r[NSTG];
  assign out_chan.notify_opened = f7_r.notify_opened;
  assign out_chan.notify_closed = f7_r.notify_closed;
  assign out_chan.went_stale    = f7_r.went_stale;
  assign out_chan.heartbeat     = f7_r.heartbeat;
  assign out_chan.reminder      = f7_r.reminder;
  assign out_chan.door_status   = f7_r.door_status;
  assign out_chan.open_minutes  = mins7_r;
  assign out_chan.open_seconds  = secs7_r;

endmodule

### sv/remote_door_state_watchdog_top.sv
// remote_door_state_watchdog_top: door state watchdog with register file
// depends on rdsw_pkg, rdsw_if, rdsw_state and rdsw_split
//
//   channel   | dir | handshake      | payload
//   in_chan   | in  | valid / ready  | kind, now_ms
//   out_chan  | out | valid / ready  | flags, door_status, open_minutes, open_seconds
//   cfg_*     | in  | cfg_we only    | cfg_addr, cfg_wdata
//
// one request per cycle sustained while out_chan takes results; each request passes through the
// input register, then seven split stages ending in the result register; the door state
// updates on the same edge that loads the first split stage
// the state update is an unpipelined loop, the duration split is fully pipelined
// synchronous active-low reset clears state and valid bits, no clearing pass
// stalls back up stage by stage, so bubbles collapse and the input keeps taking
// requests while a result waits at the output, until all eight registers hold requests

module remote_door_state_watchdog_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rdsw_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [rdsw_pkg::CFG_W-1:0]    cfg_wdata,
  rdsw_in_if.sink                       in_chan,
  rdsw_out_if.source                    out_chan
);

  rdsw_pkg::cfg_regs_t cfg_r;
  rdsw_pkg::item_t     item;
  logic                item_valid;
  logic                item_ready;

  // register file; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_open_ms     <= rdsw_pkg::RST_TIMEOUT_OPEN;
      cfg_r.timeout_closed_ms   <= rdsw_pkg::RST_TIMEOUT_CLOSED;
      cfg_r.heartbeat_open_ms   <= rdsw_pkg::RST_HB_OPEN;
      cfg_r.heartbeat_closed_ms <= rdsw_pkg::RST_HB_CLOSED;
      cfg_r.push_interval_ms    <= rdsw_pkg::RST_PUSH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rdsw_pkg::REG_TIMEOUT_OPEN:   cfg_r.timeout_open_ms     <= cfg_wdata;
        rdsw_pkg::REG_TIMEOUT_CLOSED: cfg_r.timeout_closed_ms   <= cfg_wdata;
        rdsw_pkg::REG_HB_OPEN:        cfg_r.heartbeat_open_ms   <= cfg_wdata;
        rdsw_pkg::REG_HB_CLOSED:      cfg_r.heartbeat_closed_ms <= cfg_wdata;
        rdsw_pkg::REG_PUSH:           cfg_r.push_interval_ms    <= cfg_wdata;
        default: begin
          // writes past the last register are dropped
        end
      endcase
    end
  end

  // state tracker: registers the request, updates door state, flags the result
  rdsw_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  // duration split into minutes and seconds, ends in the result register
  rdsw_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_chan   (out_chan)
  );

  // open time fields are zero unless a reminder goes out
  a_no_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.reminder |->
      out_chan.open_minutes == '0 && out_chan.open_seconds == '0)
    else $error("open time fields set without reminder");

  // a reminder only goes out while the door stays known open
  a_rem_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.reminder |-> out_chan.door_status == rdsw_pkg::ST_OPEN)
    else $error("reminder with door not open");

  // report results carry no tick flags
  a_report_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.notify_opened || out_chan.notify_closed) |->
      !(out_chan.went_stale || out_chan.heartbeat || out_chan.reminder))
    else $error("tick flag on a report result");

  // the closed notification agrees with the reported status
  a_notify_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.notify_closed |-> out_chan.door_status == rdsw_pkg::ST_CLOSED)
    else $error("closed notification with wrong status");

endmodule

### tb/tb_remote_door_state_watchdog_top.sv
// tb_remote_door_state_watchdog_top: self-checking bench for the door state watchdog
// depends on rdsw_pkg, rdsw_if and remote_door_state_watchdog_top; reads and writes no files
// a cycle-free predictor tracks door state per request, a monitor checks every result in order

module tb_remote_door_state_watchdog_top;

  // random part size, counted in requests that the block acts on
  localparam int RAND_ITEMS  = 1550;
  localparam int PHASE_ITEMS = 195;
  // pipeline is 8 deep, leave some slack after the last result
  localparam int DRAIN       = 12;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int MAX_SHOWN   = 60;

  localparam logic [rdsw_pkg::TIME_W-1:0] MS_PER_MIN = 48'd60000;
  localparam logic [rdsw_pkg::TIME_W-1:0] MS_PER_SEC = 48'd1000;
  localparam logic [rdsw_pkg::CFG_W-1:0]  REG_MAX    = 24'hFFFFFF;

  // one expected result, field for field as on the output channel
  typedef struct packed {
    logic        opened;
    logic        closed;
    logic        stale;
    logic        beat;
    logic        remind;
    logic [1:0]  status;
    logic [15:0] minutes;
    logic [5:0]  seconds;
  } door_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rdsw_pkg::ADDR_W-1:0] cfg_addr;
  logic [rdsw_pkg::CFG_W-1:0]  cfg_wdata;

  rdsw_in_if  in_chan ();
  rdsw_out_if out_chan ();

  remote_door_state_watchdog_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // predictor copy of the register file
  logic [rdsw_pkg::CFG_W-1:0] tmo_open_r, tmo_closed_r, hb_open_r, hb_closed_r, push_r;
  // predictor copy of the tracked door state
  logic known_q, open_q;
  logic [rdsw_pkg::TIME_W-1:0] report_t, opened_t, remind_t, beat_t;

  door_result_t pending_results[$];
  int errors;
  int results_seen;
  int req_count;
  // idling switches, changed per phase
  bit in_idle_on;
  bit out_idle_on;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(64'd12 * LIMIT_CYCLES);
    $display("tb_remote_door_state_watchdog_top: done, errors");
    $finish;
  end

  // next state and result of the door tracker for one request
  function automatic door_result_t door_step(input logic [1:0] k,
                                             input logic [rdsw_pkg::TIME_W-1:0] now);
    door_result_t res;
    logic [rdsw_pkg::TIME_W-1:0] since_report, since_beat, since_remind, dur, whole_min;
    logic [rdsw_pkg::CFG_W-1:0] limit;
    res = '0;
    case (k)
      rdsw_pkg::KIND_OPEN: begin
        // only a fresh opening restarts the open duration and reminder timer
        if (!open_q) begin
          opened_t = now;
          remind_t = now;
          res.opened = 1'b1;
        end
        open_q = 1'b1;
        known_q = 1'b1;
        report_t = now;
      end
      rdsw_pkg::KIND_CLOSED: begin
        res.closed = open_q;
        open_q = 1'b0;
        known_q = 1'b1;
        report_t = now;
        opened_t = '0;
      end
      rdsw_pkg::KIND_TICK: begin
        // stale check uses the timeout of the state before this tick
        limit = open_q ? tmo_open_r : tmo_closed_r;
        since_report = now - report_t;
        if (known_q && since_report >= rdsw_pkg::TIME_W'(limit)) begin
          known_q = 1'b0;
          open_q = 1'b0;
          opened_t = '0;
          res.stale = 1'b1;
        end
        // heartbeat interval follows the state after the stale check
        limit = open_q ? hb_open_r : hb_closed_r;
        since_beat = now - beat_t;
        if (since_beat >= rdsw_pkg::TIME_W'(limit)) begin
          beat_t = now;
          res.beat = 1'b1;
        end
        since_remind = now - remind_t;
        if (known_q && open_q && since_remind >= rdsw_pkg::TIME_W'(push_r)) begin
          dur = now - opened_t;
          remind_t = now;
          res.remind = 1'b1;
          whole_min = dur / MS_PER_MIN;
          res.minutes = (whole_min > rdsw_pkg::TIME_W'(rdsw_pkg::MIN_SAT)) ?
                        rdsw_pkg::MIN_SAT : whole_min[15:0];
          res.seconds = 6'((dur % MS_PER_MIN) / MS_PER_SEC);
        end
      end
      default: ;
    endcase
    res.status = known_q ? (open_q ? rdsw_pkg::ST_OPEN : rdsw_pkg::ST_CLOSED) :
                 rdsw_pkg::ST_UNKNOWN;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t  %s mismatch on result %0d: expected %0d, actual %0d",
                 $time, name, results_seen, want, got);
    end
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [rdsw_pkg::TIME_W-1:0] rand_stamp();
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  // monitor: predict on each accepted request, check each accepted result in order
  always @(posedge clk) begin : watch
    door_result_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        pending_results.push_back(door_step(in_chan.kind, in_chan.now_ms));
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t  result %0d arrived with nothing expected", $time, results_seen);
        end else begin
          want = pending_results.pop_front();
          check_field("notify_opened", 16'(want.opened), 16'(out_chan.notify_opened));
          check_field("notify_closed", 16'(want.closed), 16'(out_chan.notify_closed));
          check_field("went_stale", 16'(want.stale), 16'(out_chan.went_stale));
          check_field("heartbeat", 16'(want.beat), 16'(out_chan.heartbeat));
          check_field("reminder", 16'(want.remind), 16'(out_chan.reminder));
          check_field("door_status", 16'(want.status), 16'(out_chan.door_status));
          check_field("open_minutes", want.minutes, out_chan.open_minutes);
          check_field("open_seconds", 16'(want.seconds), 16'(out_chan.open_seconds));
        end
      end
    end
  end

  // result side back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready = 1'b0;
      stall_left--;
    end else if (!out_idle_on) begin
      out_chan.ready = 1'b1;
    end else begin
      stall_left = pick_gap();
      out_chan.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // one request: optional idle gap, then hold valid until the block takes it
  task automatic send_req(input logic [1:0] k, input logic [rdsw_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.kind = k;
    in_chan.now_ms = stamp;
    do @(posedge clk); while (!in_chan.ready);
    if (k != rdsw_pkg::KIND_IGNORE) req_count++;
  endtask

  // wait until every request has produced its result and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rdsw_pkg::ADDR_W-1:0] idx,
                           input logic [rdsw_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    case (idx)
      rdsw_pkg::REG_TIMEOUT_OPEN:   tmo_open_r = val;
      rdsw_pkg::REG_TIMEOUT_CLOSED: tmo_closed_r = val;
      rdsw_pkg::REG_HB_OPEN:        hb_open_r = val;
      rdsw_pkg::REG_HB_CLOSED:      hb_closed_r = val;
      rdsw_pkg::REG_PUSH:           push_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_regs(input logic [rdsw_pkg::CFG_W-1:0] t_open,
                           input logic [rdsw_pkg::CFG_W-1:0] t_closed,
                           input logic [rdsw_pkg::CFG_W-1:0] b_open,
                           input logic [rdsw_pkg::CFG_W-1:0] b_closed,
                           input logic [rdsw_pkg::CFG_W-1:0] push);
    write_reg(rdsw_pkg::REG_TIMEOUT_OPEN, t_open);
    write_reg(rdsw_pkg::REG_TIMEOUT_CLOSED, t_closed);
    write_reg(rdsw_pkg::REG_HB_OPEN, b_open);
    write_reg(rdsw_pkg::REG_HB_CLOSED, b_closed);
    write_reg(rdsw_pkg::REG_PUSH, push);
  endtask

  // report handling at reset settings: first report on unknown, repeats, ignored kind
  task automatic test_report_transitions();
    send_req(rdsw_pkg::KIND_TICK, 48'd0);
    send_req(rdsw_pkg::KIND_IGNORE, 48'd5);
    send_req(rdsw_pkg::KIND_CLOSED, 48'd1000);     // unknown -> closed, silent
    send_req(rdsw_pkg::KIND_CLOSED, 48'd2000);     // closed again, silent
    send_req(rdsw_pkg::KIND_OPEN, 48'd3000);       // opened
    send_req(rdsw_pkg::KIND_OPEN, 48'd4000);       // repeated open, refresh only
    send_req(rdsw_pkg::KIND_IGNORE, 48'd4500);     // ignored while open
    send_req(rdsw_pkg::KIND_CLOSED, 48'd40000);    // closed from open
    send_req(rdsw_pkg::KIND_OPEN, 48'd50000);
  endtask

  // heartbeat on the open interval, then stale, then heartbeat on the closed interval
  task automatic test_stale_and_heartbeat();
    send_req(rdsw_pkg::KIND_TICK, 48'd84000);
    send_req(rdsw_pkg::KIND_TICK, 48'd96000);
    send_req(rdsw_pkg::KIND_TICK, 48'd384000);
  endtask

  // reminder split, backwards time with saturated minutes, wrap of the time stamp
  task automatic test_reminder_split();
    logic [rdsw_pkg::TIME_W-1:0] t0;
    t0 = 48'h0000_1000_0000;
    settle();
    load_regs(REG_MAX, REG_MAX, REG_MAX, 24'd1, 24'd1000);
    send_req(rdsw_pkg::KIND_OPEN, t0);
    send_req(rdsw_pkg::KIND_TICK, t0 + 48'd61999);  // one minute one second
    send_req(rdsw_pkg::KIND_TICK, t0 + 48'd62500);  // too soon for the next reminder
    send_req(rdsw_pkg::KIND_OPEN, t0 - 48'd1);      // repeated open, earlier stamp
    send_req(rdsw_pkg::KIND_TICK, t0 - 48'd1);      // duration wraps huge, minutes saturate
    send_req(rdsw_pkg::KIND_CLOSED, t0);
    send_req(rdsw_pkg::KIND_TICK, 48'hFFFF_FFFF_FFFF);
    send_req(rdsw_pkg::KIND_TICK, 48'd0);           // time wraps past the top
  endtask

  // zero registers: every applicable check fires on each tick, stale only while the open timeout is zero
  task automatic test_zero_registers();
    settle();
    load_regs('0, '0, '0, '0, '0);
    send_req(rdsw_pkg::KIND_OPEN, 48'd100);
    send_req(rdsw_pkg::KIND_TICK, 48'd100);
    settle();
    write_reg(rdsw_pkg::REG_TIMEOUT_OPEN, REG_MAX);
    send_req(rdsw_pkg::KIND_OPEN, 48'd200);
    send_req(rdsw_pkg::KIND_TICK, 48'd200);         // reminder with zero duration
  endtask

  // phases of random traffic, each with its own register set and time scale
  task automatic test_random_traffic();
    int p, r, n, span, base, phase_base;
    logic [rdsw_pkg::TIME_W-1:0] clock_ms, stamp;
    logic [1:0] k;
    p = 0;
    base = req_count;
    while (req_count - base < RAND_ITEMS) begin
      settle();
      case (p)
        0: begin
          span = 20000;
          load_regs(rdsw_pkg::RST_TIMEOUT_OPEN, rdsw_pkg::RST_TIMEOUT_CLOSED,
                    rdsw_pkg::RST_HB_OPEN, rdsw_pkg::RST_HB_CLOSED, rdsw_pkg::RST_PUSH);
        end
        1: begin
          span = 3000000;
          load_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        end
        2: begin
          span = 3;
          load_regs(24'd1, 24'd1, 24'd1, 24'd1, 24'd1);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: span = 50;
            1: span = 2000;
            default: span = 40000;
          endcase
          load_regs(24'($urandom_range(span / 2 + 1, span * 6)),
                    24'($urandom_range(span / 2 + 1, span * 6)),
                    24'($urandom_range(span / 2 + 1, span * 6)),
                    24'($urandom_range(span / 2 + 1, span * 6)),
                    24'($urandom_range(span / 2 + 1, span * 6)));
        end
      endcase
      // every fourth phase runs with no idling at all
      in_idle_on = (p % 4 != 3) && ($urandom_range(0, 4) != 0);
      out_idle_on = (p % 4 != 3) && ($urandom_range(0, 4) != 0);
      // start somewhere random, half the time just below the wrap point
      if ($urandom_range(0, 1) == 0) clock_ms = rand_stamp();
      else clock_ms = '0 - rdsw_pkg::TIME_W'($urandom_range(0, span * 20));
      phase_base = req_count;
      while (req_count - phase_base < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // open session with ticks and refreshing reports, usually closed at the end
          send_req(rdsw_pkg::KIND_OPEN, clock_ms);
          n = $urandom_range(2, 20);
          repeat (n) begin
            clock_ms += $urandom_range(0, span);
            if ($urandom_range(0, 2) == 0) send_req(rdsw_pkg::KIND_OPEN, clock_ms);
            else send_req(rdsw_pkg::KIND_TICK, clock_ms);
          end
          if ($urandom_range(0, 4) != 0) begin
            clock_ms += $urandom_range(0, span);
            send_req(rdsw_pkg::KIND_CLOSED, clock_ms);
          end
        end else if (r < 65) begin
          send_req(rdsw_pkg::KIND_CLOSED, clock_ms);
          n = $urandom_range(1, 8);
          repeat (n) begin
            clock_ms += $urandom_range(0, span);
            send_req(rdsw_pkg::KIND_TICK, clock_ms);
          end
        end else if (r < 80) begin
          n = $urandom_range(1, 10);
          repeat (n) begin
            clock_ms += $urandom_range(0, 2 * span);
            send_req(rdsw_pkg::KIND_TICK, clock_ms);
          end
        end else if (r < 90) begin
          // long silence so the state can go stale
          clock_ms += $urandom_range(2 * span, 10 * span);
          send_req(rdsw_pkg::KIND_TICK, clock_ms);
        end else begin
          // noise: any kind, stamps from anywhere or slightly in the past
          k = 2'($urandom_range(0, 3));
          case ($urandom_range(0, 2))
            0: stamp = rand_stamp();
            1: stamp = clock_ms - rdsw_pkg::TIME_W'($urandom_range(0, span * 4));
            default: stamp = clock_ms;
          endcase
          send_req(k, stamp);
          if ($urandom_range(0, 2) == 0) clock_ms = stamp;
        end
      end
      p++;
    end
  endtask

  initial begin
    // every block input known from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.kind = rdsw_pkg::KIND_TICK;
    in_chan.now_ms = '0;
    out_chan.ready = 1'b0;
    stall_left = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    errors = 0;
    results_seen = 0;
    req_count = 0;
    // predictor at its reset point
    tmo_open_r = rdsw_pkg::RST_TIMEOUT_OPEN;
    tmo_closed_r = rdsw_pkg::RST_TIMEOUT_CLOSED;
    hb_open_r = rdsw_pkg::RST_HB_OPEN;
    hb_closed_r = rdsw_pkg::RST_HB_CLOSED;
    push_r = rdsw_pkg::RST_PUSH;
    known_q = 1'b0;
    open_q = 1'b0;
    report_t = '0;
    opened_t = '0;
    remind_t = '0;
    beat_t = '0;

    // synchronous reset held low from time zero, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_report_transitions();
    test_stale_and_heartbeat();
    test_reminder_split();
    test_zero_registers();
    test_random_traffic();

    // drain: all results in, then watch a while for stray ones
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb_remote_door_state_watchdog_top: done, clean");
    end else begin
      $display("tb_remote_door_state_watchdog_top: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/rdsw_pkg.sv
sv/rdsw_if.sv
sv/rdsw_state.sv
sv/rdsw_split.sv
sv/remote_door_state_watchdog_top.sv
tb/tb_remote_door_state_watchdog_top.sv
